// ----- rtl/cms_pkg.sv -----
// shared constants, codes and types of the cat map coordinate scrambler
`timescale 1ns / 1ps
package cms_pkg;

  localparam int unsigned CFG_COEF_W   = 16;
  localparam int unsigned CFG_SIDE_W   = 13;
  localparam int unsigned COORD_W      = 12;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned RES_W        = CFG_SIDE_W;
  localparam int unsigned MUL_V_W      = CFG_COEF_W;
  localparam int unsigned MUL_CNT_W    = $clog2(MUL_V_W);
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned MAX_SIDE_DEF = 4096;
  localparam int unsigned EXP_BITS_DEF = 16;

  localparam logic FUNC_PREPARE = 1'b0;
  localparam logic FUNC_MAP     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CFG   = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_SHEAR_A = 2'd0,
    REG_SHEAR_B = 2'd1,
    REG_ITER    = 2'd2,
    REG_SIDE    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_SQ,
    PH_MUL,
    PH_MAP
  } phase_e;

  typedef struct packed {
    status_e              status;
    logic [COORD_W-1:0]   src_x;
    logic [COORD_W-1:0]   src_y;
  } result_t;

endpackage

// ----- rtl/cms_in_if.sv -----
// input channel of the scrambler: function code and destination coordinate
`timescale 1ns / 1ps
interface cms_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [cms_pkg::COORD_W-1:0]  coord_x;
  logic [cms_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, func, coord_x, coord_y, input ready);
  modport sink (input valid, func, coord_x, coord_y, output ready);
endinterface

// ----- rtl/cms_out_if.sv -----
// output channel of the scrambler: status and source coordinate
`timescale 1ns / 1ps
interface cms_out_if;
  logic                          valid;
  logic                          ready;
  logic [cms_pkg::STATUS_W-1:0]  status;
  logic [cms_pkg::COORD_W-1:0]   src_x;
  logic [cms_pkg::COORD_W-1:0]   src_y;

  modport source (output valid, status, src_x, src_y, input ready);
  modport sink (input valid, status, src_x, src_y, output ready);
endinterface

// ----- rtl/cat_map_coordinate_scrambler.sv -----
// Cat map coordinate scrambler top level: config port, sequencer and modular multiply unit
//
// A prepare transaction (func 0) raises [[1,a],[b,1+ab]] to the power n modulo the side
// length N and keeps the 2x2 result; a map transaction (func 1) returns
// (P00*x+P01*y, P10*x+P11*y) mod N. All arithmetic runs through one bit-serial
// multiply-reduce unit that handles the 16 multiplier bits one at a time and then adds the
// running sum in a final step. A map takes 4 products. A prepare takes 3 products for the
// base matrix, then for each of the EXP_BITS exponent bits 8 products for the squaring and
// 8 more where the bit is set. Invalid configuration and a map before a good prepare are
// answered without any products. The input is ready only while no transaction is in work;
// a finished result waits in an output register. Any register write drops the prepared
// matrix until the next prepare.
`timescale 1ns / 1ps
module cat_map_coordinate_scrambler #(
  parameter int unsigned MAX_SIDE = cms_pkg::MAX_SIDE_DEF,
  parameter int unsigned EXP_BITS = cms_pkg::EXP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cms_in_if.sink                            in_i,
  cms_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cms_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cms_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cms_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned EXP_IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int unsigned RES_W     = cms_pkg::RES_W;
  localparam int unsigned MUL_V_W   = cms_pkg::MUL_V_W;
  localparam int unsigned COORD_W   = cms_pkg::COORD_W;

  // configuration registers
  logic [cms_pkg::CFG_COEF_W-1:0] shear_a_q, shear_b_q, iter_q;
  logic [cms_pkg::CFG_SIDE_W-1:0] side_q;
  logic                           cfg_we;
  cms_pkg::reg_idx_e              cfg_idx;

  // sequencer
  cms_pkg::state_e                state_q, state_d;
  cms_pkg::phase_e                phase_q;
  logic [1:0]                     ent_q;
  logic                           term_q;
  logic [EXP_IDX_W-1:0]           exp_idx_q;
  logic [cms_pkg::MUL_CNT_W-1:0]  cnt_q;
  logic                           ready_q;
  logic                           in_ready;
  logic                           in_fire;
  logic                           out_load;
  logic                           last_op;
  logic                           prep_done;
  logic                           cfg_ok;
  logic                           e_bit;
  logic [EXP_BITS-1:0]            exp_val;

  // datapath
  logic [RES_W-1:0]               r_q;
  logic [RES_W-1:0]               part_q;
  logic [RES_W-1:0]               acc_q  [4];
  logic [RES_W-1:0]               base_q [4];
  logic [RES_W-1:0]               tmp_q  [4];
  logic [COORD_W-1:0]             pm_q   [4];
  logic [COORD_W-1:0]             x_q, y_q;
  cms_pkg::result_t               pend_q, out_q;
  logic                           out_valid_q;

  logic [RES_W-1:0]               op_u, op_acc;
  logic [MUL_V_W-1:0]             op_v;
  logic [RES_W+1:0]               dbl, sub1, side_ext;
  logic [RES_W-1:0]               r_step;
  logic [RES_W:0]                 fin_sum;
  logic [RES_W-1:0]               mod_res;
  logic [RES_W-1:0]               q_sel;

  // ---------------------------------------------------------------------------------------
  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cms_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      cms_pkg::REG_SHEAR_A: prdata = cms_pkg::APB_DATA_W'(shear_a_q);
      cms_pkg::REG_SHEAR_B: prdata = cms_pkg::APB_DATA_W'(shear_b_q);
      cms_pkg::REG_ITER:    prdata = cms_pkg::APB_DATA_W'(iter_q);
      cms_pkg::REG_SIDE:    prdata = cms_pkg::APB_DATA_W'(side_q);
      default:              prdata = '0;
    endcase
  end

  assign exp_val = iter_q[EXP_BITS-1:0];
  assign e_bit   = exp_val[exp_idx_q];
  assign cfg_ok  = (shear_a_q != '0) && (shear_b_q != '0) && (exp_val != '0) &&
                   (side_q >= cms_pkg::CFG_SIDE_W'(2)) && (32'(side_q) <= MAX_SIDE);

  // ---------------------------------------------------------------------------------------
  // operand selection for the multiply-reduce unit
  always_comb begin
    op_u   = '0;
    op_v   = '0;
    op_acc = term_q ? part_q : '0;
    q_sel  = '0;
    case (phase_q)
      cms_pkg::PH_BASE: begin
        op_acc = '0;
        case (ent_q)
          2'd0: begin
            op_u = RES_W'(1);
            op_v = shear_a_q;
          end
          2'd1: begin
            op_u = RES_W'(1);
            op_v = shear_b_q;
          end
          default: begin
            // 1 + a*b
            op_u   = base_q[1];
            op_v   = {{(MUL_V_W-RES_W){1'b0}}, base_q[2]};
            op_acc = RES_W'(1);
          end
        endcase
      end
      cms_pkg::PH_SQ, cms_pkg::PH_MUL: begin
        q_sel = (phase_q == cms_pkg::PH_SQ) ? acc_q[{term_q, ent_q[0]}]
                                            : base_q[{term_q, ent_q[0]}];
        op_u  = acc_q[{ent_q[1], term_q}];
        op_v  = {{(MUL_V_W-RES_W){1'b0}}, q_sel};
      end
      cms_pkg::PH_MAP: begin
        // stored entries are below N, so reducing x and y first is not needed
        op_u = {{(RES_W-COORD_W){1'b0}}, pm_q[{ent_q[0], term_q}]};
        op_v = term_q ? {{(MUL_V_W-COORD_W){1'b0}}, y_q} : {{(MUL_V_W-COORD_W){1'b0}}, x_q};
      end
      default: begin
        op_u = '0;
      end
    endcase
  end

  // one multiplier bit per cycle: r = (2r + bit*u) mod N, at most two subtractions
  always_comb begin
    side_ext = {2'b00, side_q};
    dbl      = {1'b0, r_q, 1'b0} + (op_v[cnt_q] ? {2'b00, op_u} : '0);
    sub1     = (dbl >= side_ext) ? (dbl - side_ext) : dbl;
    r_step   = (sub1 >= side_ext) ? RES_W'(sub1 - side_ext) : sub1[RES_W-1:0];
    fin_sum  = {1'b0, r_q} + {1'b0, op_acc};
    mod_res  = (fin_sum >= {1'b0, side_q}) ? RES_W'(fin_sum - {1'b0, side_q})
                                           : fin_sum[RES_W-1:0];
  end

  // ---------------------------------------------------------------------------------------
  // sequencer
  always_comb begin
    last_op = 1'b0;
    case (phase_q)
      cms_pkg::PH_SQ:  last_op = term_q && (ent_q == 2'd3) && !e_bit && (exp_idx_q == '0);
      cms_pkg::PH_MUL: last_op = term_q && (ent_q == 2'd3) && (exp_idx_q == '0);
      cms_pkg::PH_MAP: last_op = term_q && ent_q[0];
      default:         last_op = 1'b0;
    endcase
  end

  assign prep_done = (state_q == cms_pkg::ST_FIN) && last_op && (phase_q != cms_pkg::PH_MAP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cms_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.func == cms_pkg::FUNC_PREPARE) begin
            state_d = cfg_ok ? cms_pkg::ST_STEP : cms_pkg::ST_DONE;
          end else begin
            state_d = ready_q ? cms_pkg::ST_STEP : cms_pkg::ST_DONE;
          end
        end
      end
      cms_pkg::ST_STEP: begin
        if (cnt_q == '0) state_d = cms_pkg::ST_FIN;
      end
      cms_pkg::ST_FIN: begin
        state_d = last_op ? cms_pkg::ST_DONE : cms_pkg::ST_STEP;
      end
      cms_pkg::ST_DONE: begin
        if (out_load) state_d = cms_pkg::ST_IDLE;
      end
      default: state_d = cms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_q == cms_pkg::ST_IDLE);
    out_load = (state_q == cms_pkg::ST_DONE) && (!out_valid_q || out_o.ready);
  end

  assign in_fire     = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_q.status;
  assign out_o.src_x  = out_q.src_x;
  assign out_o.src_y  = out_q.src_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_a_q   <= cms_pkg::CFG_COEF_W'(1);
      shear_b_q   <= cms_pkg::CFG_COEF_W'(1);
      iter_q      <= cms_pkg::CFG_COEF_W'(1);
      side_q      <= cms_pkg::CFG_SIDE_W'(2);
      phase_q     <= cms_pkg::PH_BASE;
      ent_q       <= '0;
      term_q      <= 1'b0;
      exp_idx_q   <= '0;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pm_q        <= '{default: '0};
    end else begin
      case (state_q)
        cms_pkg::ST_IDLE: begin
          if (in_fire) begin
            ent_q  <= '0;
            term_q <= 1'b0;
            cnt_q  <= cms_pkg::MUL_CNT_W'(MUL_V_W - 1);
            if (in_i.func == cms_pkg::FUNC_PREPARE) begin
              phase_q <= cms_pkg::PH_BASE;
              if (!cfg_ok) ready_q <= 1'b0;
            end else begin
              phase_q <= cms_pkg::PH_MAP;
            end
          end
        end
        cms_pkg::ST_STEP: begin
          cnt_q <= cnt_q - 1'b1;
        end
        cms_pkg::ST_FIN: begin
          cnt_q <= cms_pkg::MUL_CNT_W'(MUL_V_W - 1);
          case (phase_q)
            cms_pkg::PH_BASE: begin
              if (ent_q == 2'd2) begin
                phase_q   <= cms_pkg::PH_SQ;
                ent_q     <= '0;
                exp_idx_q <= EXP_IDX_W'(EXP_BITS - 1);
              end else begin
                ent_q <= ent_q + 1'b1;
              end
            end
            cms_pkg::PH_SQ, cms_pkg::PH_MUL: begin
              term_q <= !term_q;
              if (term_q) begin
                ent_q <= ent_q + 1'b1;
                if (ent_q == 2'd3) begin
                  if ((phase_q == cms_pkg::PH_SQ) && e_bit) begin
                    phase_q <= cms_pkg::PH_MUL;
                  end else begin
                    phase_q <= cms_pkg::PH_SQ;
                    if (exp_idx_q == '0) begin
                      ready_q <= 1'b1;
                    end else begin
                      exp_idx_q <= exp_idx_q - 1'b1;
                    end
                  end
                end
              end
            end
            cms_pkg::PH_MAP: begin
              term_q <= !term_q;
              if (term_q) ent_q <= ent_q + 1'b1;
            end
            default: begin
              phase_q <= cms_pkg::PH_BASE;
            end
          endcase
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase

      if (prep_done) begin
        pm_q[0] <= tmp_q[0][COORD_W-1:0];
        pm_q[1] <= tmp_q[1][COORD_W-1:0];
        pm_q[2] <= tmp_q[2][COORD_W-1:0];
        pm_q[3] <= mod_res[COORD_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          cms_pkg::REG_SHEAR_A: shear_a_q <= pwdata[cms_pkg::CFG_COEF_W-1:0];
          cms_pkg::REG_SHEAR_B: shear_b_q <= pwdata[cms_pkg::CFG_COEF_W-1:0];
          cms_pkg::REG_ITER:    iter_q    <= pwdata[cms_pkg::CFG_COEF_W-1:0];
          cms_pkg::REG_SIDE:    side_q    <= pwdata[cms_pkg::CFG_SIDE_W-1:0];
          default:              side_q    <= side_q;
        endcase
        ready_q <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      cms_pkg::ST_IDLE: begin
        r_q <= '0;
        if (in_fire) begin
          x_q <= in_i.coord_x;
          y_q <= in_i.coord_y;
          pend_q.src_x <= '0;
          pend_q.src_y <= '0;
          if (in_i.func == cms_pkg::FUNC_PREPARE) begin
            pend_q.status <= cfg_ok ? cms_pkg::STAT_OK : cms_pkg::STAT_BAD_CFG;
          end else begin
            pend_q.status <= ready_q ? cms_pkg::STAT_OK : cms_pkg::STAT_NOT_READY;
          end
        end
      end
      cms_pkg::ST_STEP: begin
        r_q <= r_step;
      end
      cms_pkg::ST_FIN: begin
        r_q <= '0;
        case (phase_q)
          cms_pkg::PH_BASE: begin
            case (ent_q)
              2'd0: begin
                base_q[0] <= RES_W'(1);
                base_q[1] <= mod_res;
              end
              2'd1: base_q[2] <= mod_res;
              default: begin
                base_q[3] <= mod_res;
                // identity start for square-and-multiply
                acc_q[0]  <= RES_W'(1);
                acc_q[1]  <= '0;
                acc_q[2]  <= '0;
                acc_q[3]  <= RES_W'(1);
              end
            endcase
          end
          cms_pkg::PH_SQ, cms_pkg::PH_MUL: begin
            if (!term_q) begin
              part_q <= mod_res;
            end else begin
              tmp_q[ent_q] <= mod_res;
              if (ent_q == 2'd3) begin
                acc_q[0] <= tmp_q[0];
                acc_q[1] <= tmp_q[1];
                acc_q[2] <= tmp_q[2];
                acc_q[3] <= mod_res;
              end
            end
          end
          cms_pkg::PH_MAP: begin
            if (!term_q) begin
              part_q <= mod_res;
            end else if (!ent_q[0]) begin
              tmp_q[0] <= mod_res;
            end else begin
              pend_q.src_x <= tmp_q[0][COORD_W-1:0];
              pend_q.src_y <= mod_res[COORD_W-1:0];
            end
          end
          default: begin
            part_q <= part_q;
          end
        endcase
      end
      cms_pkg::ST_DONE: begin
        if (out_load) out_q <= pend_q;
      end
      default: begin
        r_q <= r_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // checks

  // running residue stays reduced while the unit iterates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cms_pkg::ST_STEP) |-> (r_q < side_q))
    else $error("residue not below modulus during multiply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cms_pkg::ST_FIN) |-> (mod_res < side_q))
    else $error("multiply-reduce result not below modulus");

  // a register write always drops the prepared matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> !ready_q)
    else $error("matrix still marked ready after a register write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.func == cms_pkg::FUNC_MAP) && !ready_q) |=>
      ((state_q == cms_pkg::ST_DONE) && (pend_q.status == cms_pkg::STAT_NOT_READY)))
    else $error("map before prepare not rejected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != cms_pkg::STAT_OK)) |->
      ((out_q.src_x == '0) && (out_q.src_y == '0)))
    else $error("failed transaction carries a coordinate");

endmodule
